@@ hw/rtl/bitstream_register_write_patcher_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bitstream register write patcher
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITSTREAM_REGISTER_WRITE_PATCHER_UNIT_ASSERT_SVH
`define BITSTREAM_REGISTER_WRITE_PATCHER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BRWP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BRWP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/brwp_pkg.sv @@
// ----------------------------------------------------------------------------
// brwp_pkg
// Types, codes and constants shared by the bitstream patcher modules.
// ----------------------------------------------------------------------------
package brwp_pkg;

	localparam int SCAN_LIMIT_DEF  = 256;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int ADDR_W  = 14;
	localparam int VALUE_W = 32;

	// Configuration register indexes
	localparam logic REG_TARGET_ADDRESS = 1'b0;
	localparam logic REG_NEW_VALUE      = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_SCANNING  = 2'd0;
	localparam logic [1:0] ST_REPLACED  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_ERROR     = 2'd3;

	// Sync word, first byte at index 0
	localparam logic [7:0] SYNC_WORD [4] = '{8'hAA, 8'h99, 8'h55, 8'h66};

	// Packet header kinds, bits 31:27 of the header
	localparam logic [4:0] KIND_NOP   = 5'b00100;
	localparam logic [4:0] KIND_READ  = 5'b00101;
	localparam logic [4:0] KIND_WRITE = 5'b00110;
	// Type-2 header, bits 31:29
	localparam logic [2:0] TYPE2_HDR  = 3'b010;

	// One classified byte handed from the parser to the output side
	typedef struct packed {
		logic [7:0]         data_byte;
		logic               replace;
		logic [1:0]         patch_index;
		logic [1:0]         status;
		logic [VALUE_W-1:0] old_value;
	} brwp_item_t;

endpackage

@@ hw/rtl/bitstream_register_write_patcher_unit.sv @@
// An accepted byte goes through a queue slot and the output register to the master side.
// Throughput: one byte per cycle unless the master side stalls; parser steps once per byte.
// The queue, two entries deep by default, accepts input during output stalls until full.
// Reset (arst_n low, asynchronous): parser returns to sync search, queue and output empty,
// target_address and new_value cleared to zero.
// ----------------------------------------------------------------------------
// bitstream_register_write_patcher_unit
// Passes a configuration bitstream through byte by byte and patches the data
// word of one single-word register write, reporting the original word.
// ----------------------------------------------------------------------------
module bitstream_register_write_patcher_unit #(
	parameter int SCAN_LIMIT  = brwp_pkg::SCAN_LIMIT_DEF,
	parameter int QUEUE_DEPTH = brwp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	// input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] start_of_file
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [7:0] out_byte, [39:8] old_value
	output logic [2:0]  m_axis_tuser   // [0] byte_replaced, [2:1] status
);
	import brwp_pkg::*;

	logic [ADDR_W-1:0]  target_address_q;
	logic [VALUE_W-1:0] new_value_q;
	logic               in_beat;
	logic               queue_full;
	logic               queue_empty;
	logic               queue_pop;
	brwp_item_t         parsed_item;
	brwp_item_t         head_item;

	// Hold the configuration; writes must arrive only while the unit is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q <= '0;
			new_value_q      <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TARGET_ADDRESS: target_address_q <= cfg_wdata[ADDR_W-1:0];
				REG_NEW_VALUE:      new_value_q      <= cfg_wdata[VALUE_W-1:0];
				default:            target_address_q <= target_address_q;
			endcase
		end
	end

	// Accept a beat whenever the queue has room; the output side drains it independently.
	assign s_axis_tready = !queue_full;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// Front: advance the parse state and classify the byte.
	brwp_parser #(
		.SCAN_LIMIT(SCAN_LIMIT)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_beat),
		.data_byte      (s_axis_tdata),
		.start_of_file  (s_axis_tuser),
		.target_address (target_address_q),
		.item           (parsed_item)
	);

	// Decouple the parser from output stalls.
	brwp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_beat),
		.push_item (parsed_item),
		.pop       (queue_pop),
		.head_item (head_item),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// Back: substitute patched bytes and register the result beat.
	brwp_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.empty         (queue_empty),
		.new_value     (new_value_q),
		.pop           (queue_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ hw/rtl/brwp_parser.sv @@
// ----------------------------------------------------------------------------
// brwp_parser
// Sync search and packet header walk; classifies each accepted byte.
// ----------------------------------------------------------------------------
module brwp_parser #(
	parameter int SCAN_LIMIT = brwp_pkg::SCAN_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  data_byte,
	input  logic                        start_of_file,
	input  logic [brwp_pkg::ADDR_W-1:0] target_address,
	output brwp_pkg::brwp_item_t        item
);
	import brwp_pkg::*;

	localparam int PW = $clog2(SCAN_LIMIT + 1);
	localparam logic [PW-1:0] LIMIT    = PW'(SCAN_LIMIT);
	localparam logic [PW-1:0] LAST_POS = PW'(SCAN_LIMIT - 1);

	localparam logic [2:0] PH_SYNC   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_PATCH  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [PW-1:0]      pos_q,   c_pos,   n_pos;
	logic [2:0]         phase_q, c_phase, n_phase;
	logic [1:0]         sync_q,  c_sync,  n_sync;
	logic [23:0]        hdr_q,   c_hdr,   n_hdr;
	logic [1:0]         hbs_q,   c_hbs,   n_hbs;
	logic [11:0]        skip_q,  c_skip,  n_skip;
	logic [VALUE_W-1:0] old_q,   c_old,   n_old;
	logic [1:0]         final_q, c_final, n_final;
	logic [31:0]        word;
	logic [11:0]        skip_dec;
	logic               rep;

	always_comb begin
		// a start-of-file byte sees the cleared state
		c_pos   = start_of_file ? '0 : pos_q;
		c_phase = start_of_file ? PH_SYNC : phase_q;
		c_sync  = start_of_file ? '0 : sync_q;
		c_hdr   = start_of_file ? '0 : hdr_q;
		c_hbs   = start_of_file ? '0 : hbs_q;
		c_skip  = start_of_file ? '0 : skip_q;
		c_old   = start_of_file ? '0 : old_q;
		c_final = start_of_file ? ST_SCANNING : final_q;

		n_pos   = (c_pos >= LAST_POS) ? LIMIT : c_pos + 1'b1;
		n_phase = c_phase;
		n_sync  = c_sync;
		n_hdr   = c_hdr;
		n_hbs   = c_hbs;
		n_skip  = c_skip;
		n_old   = c_old;
		n_final = c_final;
		rep     = 1'b0;
		word    = {c_hdr, data_byte};
		skip_dec = (c_skip != '0) ? c_skip - 1'b1 : c_skip;

		unique case (c_phase)
			PH_SYNC: begin
				if (c_sync != 2'd0 && data_byte == SYNC_WORD[c_sync]) begin
					if (c_sync == 2'd3) begin
						n_sync  = 2'd0;
						n_phase = PH_HEADER;
						n_hbs   = 2'd0;
					end else begin
						n_sync = c_sync + 2'd1;
					end
				end else begin
					n_sync = (c_pos < LIMIT && data_byte == SYNC_WORD[0]) ? 2'd1 : 2'd0;
				end
				if (n_phase == PH_SYNC && n_sync == 2'd0 && n_pos == LIMIT) begin
					n_phase = PH_DONE;
					n_final = ST_NOT_FOUND;
				end
			end
			PH_HEADER: begin
				n_hdr = word[23:0];
				if (c_hbs == 2'd3) begin
					n_hbs = 2'd0;
					if (word[31:27] == KIND_NOP) begin
						n_phase = PH_HEADER;
					end else if (word[31:27] == KIND_READ) begin
						n_phase = PH_DONE;
						n_final = ST_ERROR;
					end else if (word[31:27] == KIND_WRITE) begin
						if (word[26:13] != target_address) begin
							if (word[9:0] != 10'd0) begin
								n_skip  = {word[9:0], 2'b00};
								n_phase = PH_SKIP;
							end
						end else if (word[9:0] != 10'd1) begin
							n_phase = PH_DONE;
							n_final = ST_ERROR;
						end else begin
							n_phase = PH_PATCH;
							n_old   = '0;
						end
					end else if (word[31:29] == TYPE2_HDR) begin
						n_phase = PH_DONE;
						n_final = ST_NOT_FOUND;
					end else begin
						n_phase = PH_DONE;
						n_final = ST_ERROR;
					end
				end else begin
					n_hbs = c_hbs + 2'd1;
				end
			end
			PH_SKIP: begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					n_phase = PH_HEADER;
					n_hbs   = 2'd0;
				end
			end
			PH_PATCH: begin
				rep   = 1'b1;
				n_old = {c_old[VALUE_W-9:0], data_byte};
				if (c_hbs == 2'd3) begin
					n_hbs   = 2'd0;
					n_phase = PH_DONE;
					n_final = ST_REPLACED;
				end else begin
					n_hbs = c_hbs + 2'd1;
				end
			end
			default: begin
			end
		endcase

		// the next header would begin at or past the limit
		if (n_phase == PH_HEADER && n_hbs == 2'd0 && n_pos == LIMIT) begin
			n_phase = PH_DONE;
			n_final = ST_NOT_FOUND;
		end

		item.data_byte   = data_byte;
		item.replace     = rep;
		item.patch_index = c_hbs;
		item.status      = n_final;
		item.old_value   = (n_final == ST_REPLACED) ? n_old : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_SYNC;
			sync_q  <= '0;
			hdr_q   <= '0;
			hbs_q   <= '0;
			skip_q  <= '0;
			old_q   <= '0;
			final_q <= ST_SCANNING;
		end else if (accept) begin
			pos_q   <= n_pos;
			phase_q <= n_phase;
			sync_q  <= n_sync;
			hdr_q   <= n_hdr;
			hbs_q   <= n_hbs;
			skip_q  <= n_skip;
			old_q   <= n_old;
			final_q <= n_final;
		end
	end

endmodule

@@ hw/rtl/brwp_queue.sv @@
// ----------------------------------------------------------------------------
// brwp_queue
// Short first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
module brwp_queue #(
	parameter int DEPTH = brwp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  brwp_pkg::brwp_item_t push_item,
	input  logic                 pop,
	output brwp_pkg::brwp_item_t head_item,
	output logic                 full,
	output logic                 empty
);
	import brwp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	brwp_item_t    slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/brwp_emitter.sv @@
// ----------------------------------------------------------------------------
// brwp_emitter
// Output register: substitutes patched bytes and presents result beats.
// ----------------------------------------------------------------------------
module brwp_emitter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  brwp_pkg::brwp_item_t         head_item,
	input  logic                         empty,
	input  logic [brwp_pkg::VALUE_W-1:0] new_value,
	output logic                         pop,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [39:0]                  m_axis_tdata,
	output logic [2:0]                   m_axis_tuser
);
	import brwp_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       rep_q;
	logic [1:0] status_q;
	logic [VALUE_W-1:0] old_q;
	logic [7:0] out_byte;

	assign pop = !empty && (!valid_q || m_axis_tready);

	// most significant byte of the new word goes out first
	always_comb begin
		unique case (head_item.patch_index)
			2'd0: out_byte = new_value[31:24];
			2'd1: out_byte = new_value[23:16];
			2'd2: out_byte = new_value[15:8];
			2'd3: out_byte = new_value[7:0];
			default: out_byte = new_value[7:0];
		endcase
		if (!head_item.replace) begin
			out_byte = head_item.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q   <= out_byte;
			rep_q    <= head_item.replace;
			status_q <= head_item.status;
			old_q    <= head_item.old_value;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {old_q, byte_q};
	assign m_axis_tuser  = {status_q, rep_q};

endmodule

@@ hw/rtl/brwp_checker.sv @@
// ----------------------------------------------------------------------------
// brwp_checker
// Port-level checks on the result stream of the patcher unit.
// ----------------------------------------------------------------------------
`include "bitstream_register_write_patcher_unit_assert.svh"

module brwp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);
	import brwp_pkg::*;

	// a stalled beat holds
	`BRWP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"result beat changed while stalled")

	// old value shows only with replaced status
	`BRWP_ASSERT_SAME(a_old_zero, m_axis_tvalid && m_axis_tuser[2:1] != ST_REPLACED,
		m_axis_tdata[39:8] == 32'd0, "old value set without replaced status")

	// a replaced byte never carries a failure status
	`BRWP_ASSERT_SAME(a_rep_status, m_axis_tvalid && m_axis_tuser[0],
		m_axis_tuser[2:1] == ST_SCANNING || m_axis_tuser[2:1] == ST_REPLACED,
		"replaced byte with failure status")

	// no result beat straight out of reset
	`BRWP_ASSERT_SAME(a_reset_idle, $past(!arst_n), !m_axis_tvalid,
		"result beat right after reset")

endmodule

bind bitstream_register_write_patcher_unit brwp_checker u_brwp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
